/* rtl/dlpi_pkg.sv */
// Types and constants for the line-number program interpreter.
// Shared by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
package dlpi_pkg;

  localparam logic [7:0] OP_EXTENDED         = 8'd0;
  localparam logic [7:0] OP_COPY             = 8'd1;
  localparam logic [7:0] OP_ADVANCE_PC       = 8'd2;
  localparam logic [7:0] OP_ADVANCE_LINE     = 8'd3;
  localparam logic [7:0] OP_SET_FILE         = 8'd4;
  localparam logic [7:0] OP_SET_COLUMN       = 8'd5;
  localparam logic [7:0] OP_CONST_ADD_PC     = 8'd8;
  localparam logic [7:0] OP_FIXED_ADVANCE_PC = 8'd9;
  localparam logic [7:0] FIRST_SPECIAL_OP    = 8'd10;
  localparam logic [7:0] CONST_ADD_DIVIDEND  = 8'd245;

  localparam logic [7:0] EXT_END_SEQUENCE = 8'd1;
  localparam logic [7:0] EXT_SET_ADDRESS  = 8'd2;

  localparam logic [7:0] CFG_MIN_INST_LEN  = 8'd0;
  localparam logic [7:0] CFG_LINE_BASE     = 8'd1;
  localparam logic [7:0] CFG_LINE_RANGE    = 8'd2;
  localparam logic [7:0] CFG_LITTLE_ENDIAN = 8'd3;

  localparam int unsigned DIV_STEPS = 8;

  typedef enum logic [5:0] {
    PH_OPCODE = 6'b000001,
    PH_ULEB   = 6'b000010,
    PH_SLEB   = 6'b000100,
    PH_FIXED  = 6'b001000,
    PH_EXTOP  = 6'b010000,
    PH_SKIP   = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_EMIT,
    CLS_DIVMUL,
    CLS_MUL
  } cls_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic div_step;
    logic mul_lo;
    logic add_lo;
    logic mul_hi;
    logic add_hi;
    logic load_out;
  } dlpi_cmd_t;

  typedef struct packed {
    cls_t cls;
    logic special;
  } dlpi_stat_t;

endpackage

/* rtl/dlpi_if.sv */
// Request channels of the interpreter: program bytes in, table rows out.
// Depends on nothing.
`timescale 1ns / 1ps
interface dlpi_in_if;
  logic       valid;
  logic       ready;
  logic       unit_start;
  logic [7:0] code_byte;
  modport source (output valid, unit_start, code_byte, input ready);
  modport sink (input valid, unit_start, code_byte, output ready);
endinterface

interface dlpi_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] row_address;
  logic [31:0] row_file;
  logic [31:0] row_line;
  logic [31:0] row_column;
  logic        end_of_sequence;
  modport source (output valid, row_address, row_file, row_line, row_column,
                  end_of_sequence, input ready);
  modport sink (input valid, row_address, row_file, row_line, row_column,
                end_of_sequence, output ready);
endinterface

/* rtl/dlpi_ctrl.sv */
// Controller state machine: sequences decode, divide, multiply and row output.
// Depends on dlpi_pkg.
`timescale 1ns / 1ps
module dlpi_ctrl import dlpi_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dlpi_stat_t stat,
  output dlpi_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_EXEC   = 8'b00000010,
    S_DIV    = 8'b00000100,
    S_MUL_LO = 8'b00001000,
    S_ADD_LO = 8'b00010000,
    S_MUL_HI = 8'b00100000,
    S_ADD_HI = 8'b01000000,
    S_EMIT   = 8'b10000000
  } state_t;

  state_t      state;
  state_t      state_next;
  logic [2:0]  cnt;
  logic        slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        unique case (stat.cls)
          CLS_EMIT:   state_next = S_EMIT;
          CLS_DIVMUL: state_next = S_DIV;
          CLS_MUL:    state_next = S_MUL_LO;
          default:    state_next = S_IDLE;
        endcase
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == 3'(DIV_STEPS - 1)) state_next = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_ADD_LO;
      end
      S_ADD_LO: begin
        cmd.add_lo = 1'b1;
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_ADD_HI;
      end
      S_ADD_HI: begin
        cmd.add_hi = 1'b1;
        state_next = stat.special ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        cmd.load_out = slot_free;
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DIV) cnt <= cnt + 3'd1;
      else cnt <= '0;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("row loaded over an unaccepted row");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && cnt == 3'(DIV_STEPS - 1)) |=> state == S_MUL_LO)
    else $error("divider did not hand over to multiplier");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && state != S_EMIT) |=> out_valid)
    else $error("pending row dropped");

endmodule

/* rtl/dlpi_dp.sv */
// Datapath: row registers, operand decoder, bit-serial divider, split multiplier.
// Depends on dlpi_pkg; driven by dlpi_ctrl commands.
`timescale 1ns / 1ps
module dlpi_dp import dlpi_pkg::*; #(
  parameter int unsigned SetAddressBytes = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  dlpi_cmd_t   cmd,
  output dlpi_stat_t  stat,
  input  logic        in_unit_start,
  input  logic [7:0]  in_code_byte,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output logic [63:0] row_address,
  output logic [31:0] row_file,
  output logic [31:0] row_line,
  output logic [31:0] row_column,
  output logic        end_of_sequence
);

  logic [7:0]  min_inst_len;
  logic [7:0]  min_line_adv;
  logic [7:0]  line_span;
  logic        little_endian;

  logic [7:0]  byte_q;
  logic        start_q;

  logic [63:0] address, address_next;
  logic [31:0] file, file_next;
  logic [31:0] line, line_next;
  logic [31:0] column, column_next;
  phase_t      phase, phase_next;
  logic [7:0]  pending, pending_next;
  logic [63:0] acc, acc_next;
  logic [6:0]  shift, shift_next;
  logic [31:0] skip, skip_next;
  logic        eos, eos_next;
  logic        special, special_next;
  logic        use_quo, use_quo_next;
  logic [63:0] mcand, mcand_next;
  logic [7:0]  div_quo, div_quo_next;
  logic [8:0]  div_rem, div_rem_next;
  logic [8:0]  divisor, divisor_next;
  logic [39:0] prod;
  logic [63:0] mul_src;
  logic [9:0]  trial;
  logic        ge;
  cls_t        cls;
  logic [6:0]  sext_shift;
  logic [63:0] len_m1;

  assign stat.cls     = cls;
  assign stat.special = special;
  assign mul_src      = use_quo ? {56'd0, div_quo} : mcand;
  assign trial        = {div_rem, div_quo[7]};
  assign ge           = trial >= {1'b0, divisor};

  always_comb begin
    address_next = address;
    file_next    = file;
    line_next    = line;
    column_next  = column;
    phase_next   = phase;
    pending_next = pending;
    acc_next     = acc;
    shift_next   = shift;
    skip_next    = skip;
    eos_next     = eos;
    special_next = special;
    use_quo_next = use_quo;
    mcand_next   = mcand;
    div_quo_next = div_quo;
    div_rem_next = div_rem;
    divisor_next = divisor;
    cls          = CLS_NONE;
    sext_shift   = '0;
    len_m1       = '0;

    if (cmd.exec) begin
      if (start_q) begin
        address_next = '0;
        file_next    = '0;
        line_next    = 32'd1;
        column_next  = '0;
        phase_next   = PH_OPCODE;
        pending_next = '0;
        acc_next     = '0;
        shift_next   = '0;
        skip_next    = '0;
      end
      unique case (phase_next)
        PH_ULEB, PH_SLEB: begin
          if (shift_next < 7'd64)
            acc_next = acc_next | ({57'd0, byte_q[6:0]} << shift_next[5:0]);
          if (byte_q[7]) begin
            if (shift_next < 7'd64) shift_next = shift_next + 7'd7;
          end else if (phase_next == PH_SLEB) begin
            sext_shift = (shift_next < 7'd64) ? shift_next + 7'd7 : shift_next;
            if (sext_shift < 7'd64 && byte_q[6])
              acc_next = acc_next | ({64{1'b1}} << sext_shift[5:0]);
            line_next  = line_next + acc_next[31:0];
            phase_next = PH_OPCODE;
          end else begin
            phase_next = PH_OPCODE;
            priority case (pending_next)
              OP_ADVANCE_PC: begin
                mcand_next   = acc_next;
                use_quo_next = 1'b0;
                special_next = 1'b0;
                cls          = CLS_MUL;
              end
              OP_SET_FILE:   file_next = acc_next[31:0] - 32'd1;
              OP_SET_COLUMN: column_next = acc_next[31:0];
              default: begin
                len_m1       = acc_next - 64'd1;
                phase_next   = PH_EXTOP;
                pending_next = '0;
                shift_next   = '0;
                if (acc_next == 64'd0) skip_next = '0;
                else if (|len_m1[63:32]) skip_next = 32'hffff_ffff;
                else skip_next = len_m1[31:0];
                acc_next = '0;
              end
            endcase
          end
        end
        PH_FIXED: begin
          if (little_endian) begin
            if (shift_next < 7'd64)
              acc_next = acc_next | ({56'd0, byte_q} << shift_next[5:0]);
            shift_next = shift_next + 7'd8;
          end else begin
            acc_next = {acc_next[55:0], byte_q};
          end
          if (skip_next != 32'd0) skip_next = skip_next - 32'd1;
          if (skip_next == 32'd0) begin
            if (pending_next == OP_FIXED_ADVANCE_PC)
              address_next = address_next + {48'd0, acc_next[15:0]};
            else
              address_next = acc_next;
            phase_next = PH_OPCODE;
          end
        end
        PH_EXTOP: begin
          if (byte_q == EXT_END_SEQUENCE) begin
            cls          = CLS_EMIT;
            eos_next     = 1'b1;
            phase_next   = PH_OPCODE;
            pending_next = '0;
            acc_next     = '0;
            shift_next   = '0;
            skip_next    = '0;
          end else if (byte_q == EXT_SET_ADDRESS) begin
            phase_next   = PH_FIXED;
            pending_next = '0;
            acc_next     = '0;
            shift_next   = '0;
            skip_next    = 32'(SetAddressBytes);
          end else begin
            phase_next = (skip_next == 32'd0) ? PH_OPCODE : PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (skip_next != 32'd0) skip_next = skip_next - 32'd1;
          if (skip_next == 32'd0) phase_next = PH_OPCODE;
        end
        default: begin
          phase_next = PH_OPCODE;
          if (byte_q >= FIRST_SPECIAL_OP || byte_q == OP_CONST_ADD_PC) begin
            div_quo_next = (byte_q == OP_CONST_ADD_PC) ? CONST_ADD_DIVIDEND
                                                       : byte_q - FIRST_SPECIAL_OP;
            div_rem_next = '0;
            divisor_next = (line_span == 8'd0) ? 9'd256 : {1'b0, line_span};
            use_quo_next = 1'b1;
            special_next = (byte_q != OP_CONST_ADD_PC);
            eos_next     = 1'b0;
            cls          = CLS_DIVMUL;
          end else begin
            priority case (byte_q)
              OP_COPY: begin
                cls      = CLS_EMIT;
                eos_next = 1'b0;
              end
              OP_EXTENDED, OP_ADVANCE_PC, OP_ADVANCE_LINE, OP_SET_FILE,
              OP_SET_COLUMN, OP_FIXED_ADVANCE_PC: begin
                phase_next   = (byte_q == OP_ADVANCE_LINE) ? PH_SLEB :
                               (byte_q == OP_FIXED_ADVANCE_PC) ? PH_FIXED : PH_ULEB;
                pending_next = byte_q;
                acc_next     = '0;
                shift_next   = '0;
                skip_next    = (byte_q == OP_FIXED_ADVANCE_PC) ? 32'd2 : 32'd0;
              end
              default: ;
            endcase
          end
        end
      endcase
    end

    if (cmd.div_step) begin
      div_rem_next = ge ? 9'(trial - {1'b0, divisor}) : trial[8:0];
      div_quo_next = {div_quo[6:0], ge};
    end

    if (cmd.add_lo) address_next = address + {24'd0, prod};
    if (cmd.add_hi) begin
      address_next = address + {prod[31:0], 32'd0};
      if (special)
        line_next = line + {{24{min_line_adv[7]}}, min_line_adv} + {23'd0, div_rem};
    end

    if (cmd.load_out && eos) begin
      address_next = '0;
      file_next    = '0;
      line_next    = 32'd1;
      column_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_inst_len  <= 8'd1;
      min_line_adv  <= 8'hfb;
      line_span     <= 8'd14;
      little_endian <= 1'b1;
      address       <= '0;
      file          <= '0;
      line          <= 32'd1;
      column        <= '0;
      phase         <= PH_OPCODE;
      pending       <= '0;
      acc           <= '0;
      shift         <= '0;
      skip          <= '0;
      eos           <= 1'b0;
      special       <= 1'b0;
      use_quo       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MIN_INST_LEN:  min_inst_len <= cfg_data;
          CFG_LINE_BASE:     min_line_adv <= cfg_data;
          CFG_LINE_RANGE:    line_span <= cfg_data;
          CFG_LITTLE_ENDIAN: little_endian <= cfg_data[0];
          default: ;
        endcase
      end
      address <= address_next;
      file    <= file_next;
      line    <= line_next;
      column  <= column_next;
      phase   <= phase_next;
      pending <= pending_next;
      acc     <= acc_next;
      shift   <= shift_next;
      skip    <= skip_next;
      eos     <= eos_next;
      special <= special_next;
      use_quo <= use_quo_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_q  <= in_code_byte;
      start_q <= in_unit_start;
    end
    mcand   <= mcand_next;
    div_quo <= div_quo_next;
    div_rem <= div_rem_next;
    divisor <= divisor_next;
    if (cmd.mul_lo) prod <= {8'd0, mul_src[31:0]} * {32'd0, min_inst_len};
    if (cmd.mul_hi) prod <= {8'd0, mul_src[63:32]} * {32'd0, min_inst_len};
    if (cmd.load_out) begin
      row_address     <= address;
      row_file        <= file;
      row_line        <= line - 32'd1;
      row_column      <= column;
      end_of_sequence <= eos;
    end
  end

endmodule

/* rtl/dwarf2_line_program_interpreter_unit.sv */
// Top level of the line-number program interpreter.
// Depends on dlpi_pkg, dlpi_if, dlpi_ctrl and dlpi_dp.
//
// Feed the program one byte per request on in_ch; set unit_start on the first
// byte of a program. Rows (address, zero-based file, line minus one, column,
// end-of-sequence flag) leave on out_ch, at most one per byte.
// Configuration registers (min instruction length, line base, line range,
// little endian) are written through cfg_we/cfg_index/cfg_data; the user writes
// them only while idle, and the block itself does not enforce it.
// Per byte: copy and end-sequence also load a row; the end of an advance_pc
// operand forms two 32x8 partial products; const_add_pc and a special opcode
// first pass through the one-bit-per-cycle divider by line range.
// A copy or end-sequence row is valid after the execute and emit states.
// One row waits in the output register; bytes that give no row are still
// taken while it stalls, and a byte that gives a row holds until it drains.
// Reset restores the register defaults and the line-table registers.
`timescale 1ns / 1ps
module dwarf2_line_program_interpreter_unit import dlpi_pkg::*; #(
  parameter int unsigned SET_ADDRESS_BYTES = 4
) (
  input  logic       clk,
  input  logic       rst,
  dlpi_in_if.sink    in_ch,
  dlpi_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);

  dlpi_cmd_t  cmd;
  dlpi_stat_t stat;

  dlpi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dlpi_dp #(
    .SetAddressBytes (SET_ADDRESS_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .in_unit_start   (in_ch.unit_start),
    .in_code_byte    (in_ch.code_byte),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .row_address     (out_ch.row_address),
    .row_file        (out_ch.row_file),
    .row_line        (out_ch.row_line),
    .row_column      (out_ch.row_column),
    .end_of_sequence (out_ch.end_of_sequence)
  );

endmodule

/* sim/dlpi_row_checker.sv */
// Row checker for the line-number program interpreter: keeps its own copy of the
// line-table registers, predicts rows from accepted bytes and compares them.
// Depends on dlpi_pkg and dlpi_if.
`timescale 1ns / 1ps
module dlpi_row_checker import dlpi_pkg::*; #(
  parameter int unsigned SET_ADDRESS_BYTES = 4
) (
  input  logic       clk,
  input  logic       rst,
  dlpi_in_if         in_ch,
  dlpi_out_if        out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         fails,
  output int         rows_pending,
  output int         rows_seen,
  output int         ends_seen
);

  typedef struct packed {
    logic [63:0] address;
    logic [31:0] file;
    logic [31:0] line;
    logic [31:0] column;
    logic        eos;
  } row_t;

  row_t row_q[$];

  logic [7:0]  min_len;
  logic [7:0]  min_line_adv;
  logic [7:0]  line_span;
  logic        little_end;

  logic [63:0] addr_r;
  logic [31:0] file_r;
  logic [31:0] line_r;
  logic [31:0] col_r;
  phase_t      phase;
  logic [7:0]  pend_op;
  logic [63:0] acc;
  logic [7:0]  shift;
  logic [31:0] skip;

  assign rows_pending = row_q.size();

  task automatic clear_rows();
    addr_r = '0;
    file_r = '0;
    line_r = 32'd1;
    col_r  = '0;
  endtask

  task automatic start_operand(phase_t ph, logic [7:0] op, logic [31:0] cnt);
    phase   = ph;
    pend_op = op;
    acc     = '0;
    shift   = '0;
    skip    = cnt;
  endtask

  task automatic push_row(logic eos);
    row_t r;
    r.address = addr_r;
    r.file    = file_r;
    r.line    = line_r - 32'd1;
    r.column  = col_r;
    r.eos     = eos;
    row_q.insert(row_q.size(), r);
  endtask

  // returns 1 on the final byte of a LEB operand
  function automatic logic leb_add(logic [7:0] b);
    if (shift < 64) acc |= {57'd0, b[6:0]} << shift;
    if (b[7]) begin
      if (shift < 64) shift = shift + 8'd7;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic run_opcode(logic [7:0] op);
    logic [31:0] adj, rng;
    int signed   adv;
    rng = (line_span == 0) ? 32'd256 : {24'd0, line_span};
    if (op >= FIRST_SPECIAL_OP) begin
      adj = {24'd0, op - FIRST_SPECIAL_OP};
      adv = $signed(min_line_adv) + int'(adj % rng);
      addr_r += 64'(adj / rng) * 64'(min_len);
      line_r += 32'(adv);
      push_row(1'b0);
    end else begin
      case (op)
        OP_EXTENDED:   start_operand(PH_ULEB, OP_EXTENDED, 0);
        OP_COPY:       push_row(1'b0);
        OP_ADVANCE_PC, OP_SET_FILE, OP_SET_COLUMN: start_operand(PH_ULEB, op, 0);
        OP_ADVANCE_LINE: start_operand(PH_SLEB, op, 0);
        OP_CONST_ADD_PC: addr_r += 64'({24'd0, CONST_ADD_DIVIDEND} / rng) * 64'(min_len);
        OP_FIXED_ADVANCE_PC: start_operand(PH_FIXED, op, 2);
        default: ;
      endcase
    end
  endtask

  task automatic predict_byte(logic us, logic [7:0] b);
    logic [63:0] len;
    logic [7:0]  s;
    if (us) begin
      clear_rows();
      start_operand(PH_OPCODE, 8'd0, 0);
    end
    case (phase)
      PH_ULEB: begin
        if (leb_add(b)) begin
          phase = PH_OPCODE;
          if (pend_op == OP_ADVANCE_PC) addr_r += acc * 64'(min_len);
          else if (pend_op == OP_SET_FILE) file_r = 32'(acc - 64'd1);
          else if (pend_op == OP_SET_COLUMN) col_r = acc[31:0];
          else begin
            len = (acc == 0) ? 64'd0 : acc - 64'd1;
            if (len > 64'hffff_ffff) len = 64'hffff_ffff;
            start_operand(PH_EXTOP, 8'd0, len[31:0]);
          end
        end
      end
      PH_SLEB: begin
        if (leb_add(b)) begin
          s = (shift < 64) ? shift + 8'd7 : shift;
          if (s < 64 && b[6]) acc |= ~64'd0 << s;
          line_r += acc[31:0];
          phase = PH_OPCODE;
        end
      end
      PH_FIXED: begin
        if (little_end) begin
          if (shift < 64) acc |= {56'd0, b} << shift;
          shift = shift + 8'd8;
        end else begin
          acc = {acc[55:0], b};
        end
        if (skip > 0) skip--;
        if (skip == 0) begin
          if (pend_op == OP_FIXED_ADVANCE_PC) addr_r += {48'd0, acc[15:0]};
          else addr_r = acc;
          phase = PH_OPCODE;
        end
      end
      PH_EXTOP: begin
        if (b == EXT_END_SEQUENCE) begin
          push_row(1'b1);
          clear_rows();
          start_operand(PH_OPCODE, 8'd0, 0);
        end else if (b == EXT_SET_ADDRESS) begin
          start_operand(PH_FIXED, 8'd0, SET_ADDRESS_BYTES);
        end else begin
          phase = (skip == 0) ? PH_OPCODE : PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (skip > 0) skip--;
        if (skip == 0) phase = PH_OPCODE;
      end
      default: begin
        phase = PH_OPCODE;
        run_opcode(b);
      end
    endcase
  endtask

  task automatic check_row();
    row_t got, want;
    got = {out_ch.row_address, out_ch.row_file, out_ch.row_line, out_ch.row_column,
           out_ch.end_of_sequence};
    rows_seen++;
    if (out_ch.end_of_sequence) ends_seen++;
    if (row_q.size() == 0) begin
      $display("%0t: unexpected row %h", $time, got);
      fails++;
      return;
    end
    want = row_q.pop_front();
    if (got.address !== want.address) begin
      $display("%0t: address expected %h actual %h", $time, want.address, got.address);
      fails++;
    end
    if (got.file !== want.file) begin
      $display("%0t: file expected %h actual %h", $time, want.file, got.file);
      fails++;
    end
    if (got.line !== want.line) begin
      $display("%0t: line expected %h actual %h", $time, want.line, got.line);
      fails++;
    end
    if (got.column !== want.column) begin
      $display("%0t: column expected %h actual %h", $time, want.column, got.column);
      fails++;
    end
    if (got.eos !== want.eos) begin
      $display("%0t: end_of_sequence expected %b actual %b", $time, want.eos, got.eos);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fails        = 0;
      rows_seen    = 0;
      ends_seen    = 0;
      min_len      = 8'd1;
      min_line_adv = 8'hfb;
      line_span    = 8'd14;
      little_end   = 1'b1;
      clear_rows();
      start_operand(PH_OPCODE, 8'd0, 0);
      row_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_INST_LEN:  min_len      = cfg_data;
          CFG_LINE_BASE:     min_line_adv = cfg_data;
          CFG_LINE_RANGE:    line_span    = cfg_data;
          CFG_LITTLE_ENDIAN: little_end   = cfg_data[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) predict_byte(in_ch.unit_start, in_ch.code_byte);
      if (out_ch.valid && out_ch.ready) check_row();
    end
  end

  final begin
    if (row_q.size() != 0) $display("%0t: %0d rows never arrived", $time, row_q.size());
  end

endmodule

/* sim/tb_dwarf2_line_program_interpreter_unit.sv */
// Top of the interpreter testbench: clock, reset, byte stimulus and verdict.
// Depends on dlpi_pkg, dlpi_if, dlpi_row_checker and the interpreter RTL.
`timescale 1ns / 1ps
module tb_dwarf2_line_program_interpreter_unit;
  import dlpi_pkg::*;

  localparam int TOTAL_BYTES = 1000;
  localparam int CYCLE_LIMIT = 600000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  int         fails, rows_pending, rows_seen, ends_seen;
  int         bytes_sent = 0;
  int         cycles = 0;
  int         send_idle = 27;
  int         recv_idle = 65;

  dlpi_in_if  in_ch();
  dlpi_out_if out_ch();

  dwarf2_line_program_interpreter_unit #(.SET_ADDRESS_BYTES(4)) dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  dlpi_row_checker #(.SET_ADDRESS_BYTES(4)) u_checker (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .rows_pending(rows_pending), .rows_seen(rows_seen),
    .ends_seen(ends_seen)
  );

  always #10 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.unit_start = 1'b0;
    in_ch.code_byte = '0;
    out_ch.ready = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready = !rst && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send(logic us, logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.unit_start = us;
    in_ch.code_byte = b;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
    bytes_sent++;
    if (bytes_sent > 2 * TOTAL_BYTES / 3) begin
      send_idle = 0;
      recv_idle = 0;
    end else if (bytes_sent > TOTAL_BYTES / 3) begin
      send_idle = 65;
      recv_idle = 27;
    end
  endtask

  task automatic send_uleb(logic [63:0] v, int pad);
    logic [7:0] b;
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 0 || pad > 0) b[7] = 1'b1;
      send(1'b0, b);
    end while (v != 0);
    while (pad > 0) begin
      pad--;
      send(1'b0, pad > 0 ? 8'h80 : 8'h00);
    end
  endtask

  task automatic send_sleb(longint v);
    logic [7:0] b;
    logic       done;
    do begin
      b = {1'b0, v[6:0]};
      v = v >>> 7;
      done = (v == 0 && !b[6]) || (v == -1 && b[6]);
      if (!done) b[7] = 1'b1;
      send(1'b0, b);
    end while (!done);
  endtask

  task automatic ext_op(logic [7:0] code, int len);
    send(1'b0, OP_EXTENDED);
    send_uleb(len, 0);
    send(1'b0, code);
  endtask

  task automatic random_op();
    int k, n;
    logic [63:0] v;
    v = {$urandom, $urandom} >> $urandom_range(63);
    case ($urandom_range(19))
      0, 1, 2, 3, 4: send($urandom_range(9) == 0, 8'($urandom_range(255, 10)));
      5: send(1'b0, OP_COPY);
      6: send_uleb(OP_ADVANCE_PC == 0 ? 0 : 0, 0);
      7: begin send(1'b0, OP_ADVANCE_PC); send_uleb(v, $urandom_range(3) == 0 ? 4 : 0); end
      8: begin send(1'b0, OP_ADVANCE_LINE); send_sleb(longint'(v) - 64'd1000); end
      9: begin send(1'b0, OP_SET_FILE); send_uleb(v[15:0], 0); end
      10: begin send(1'b0, OP_SET_COLUMN); send_uleb(v[31:0], 0); end
      11: send(1'b0, OP_CONST_ADD_PC);
      12: begin
        send(1'b0, OP_FIXED_ADVANCE_PC);
        send(1'b0, 8'($urandom));
        send(1'b0, 8'($urandom));
      end
      13: send(1'b0, 8'($urandom_range(7, 6)));
      14: begin
        ext_op(EXT_SET_ADDRESS, $urandom_range(5));
        repeat (4) send(1'b0, 8'($urandom));
      end
      15: ext_op(EXT_END_SEQUENCE, $urandom_range(2));
      16: begin
        n = $urandom_range(4);
        ext_op(8'($urandom_range(255, 3)), n);
        for (k = 1; k < n; k++) send(1'b0, 8'($urandom));
      end
      17: send($urandom_range(1), 8'($urandom));
      default: begin
        send(1'b0, OP_ADVANCE_LINE);
        send(1'b1, 8'($urandom));
      end
    endcase
  endtask

  task automatic drain();
    wait (rows_pending == 0);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_regs(logic [7:0] ml, logic [7:0] lb, logic [7:0] lr, logic le);
    drain();
    cfg_we = 1'b1;
    cfg_index = CFG_MIN_INST_LEN;  cfg_data = ml;         @(negedge clk);
    cfg_index = CFG_LINE_BASE;     cfg_data = lb;         @(negedge clk);
    cfg_index = CFG_LINE_RANGE;    cfg_data = lr;         @(negedge clk);
    cfg_index = CFG_LITTLE_ENDIAN; cfg_data = {7'd0, le}; @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_phase(int n);
    int stop;
    stop = bytes_sent + n;
    send(1'b1, OP_COPY);
    while (bytes_sent < stop) random_op();
    ext_op(EXT_END_SEQUENCE, 1);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst = 1'b0;

    send(1'b1, FIRST_SPECIAL_OP);
    send(1'b0, 8'd255);
    send(1'b0, OP_COPY);
    send(1'b0, OP_CONST_ADD_PC);
    send(1'b0, OP_FIXED_ADVANCE_PC); send(1'b0, 8'hff); send(1'b0, 8'hff);
    send(1'b0, OP_ADVANCE_LINE); send_sleb(-64);
    send(1'b0, OP_SET_FILE); send_uleb(0, 0);
    send(1'b0, OP_SET_COLUMN); send_uleb(64'hffff_ffff_ffff_ffff, 2);
    send(1'b0, OP_ADVANCE_PC); send_uleb(3, 0);
    ext_op(EXT_SET_ADDRESS, 0); send(1'b0, 8'h12); send(1'b0, 8'h34);
    send(1'b0, 8'h56); send(1'b0, 8'h78);
    ext_op(8'd3, 3); send(1'b0, 8'haa); send(1'b0, 8'h55);
    send(1'b0, OP_COPY);
    ext_op(EXT_END_SEQUENCE, 0);

    random_phase(200);
    set_regs(8'd255, 8'h80, 8'd1, 1'b0);
    random_phase(200);
    set_regs(8'd1, 8'h7f, 8'd255, 1'b1);
    random_phase(200);
    set_regs(8'd4, 8'hfd, 8'd0, 1'b0);
    random_phase(150);
    set_regs(8'($urandom_range(255, 1)), 8'($urandom), 8'($urandom_range(255, 1)), 1'b1);
    random_phase(200);

    drain();
    $display("Sent %0d program bytes under five register settings;", bytes_sent);
    $display("%0d rows checked, %0d ending a sequence.", rows_seen, ends_seen);
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
